[rtl/coalescing_request_table_assert.svh]
// Assertion macros used by the request table RTL.
// CRT_ASSERT_IMP : antecedent implies consequent in the same cycle.
// CRT_ASSERT_NXT : antecedent implies consequent in the following cycle.
`ifndef COALESCING_REQUEST_TABLE_ASSERT_SVH
`define COALESCING_REQUEST_TABLE_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define CRT_ASSERT_IMP(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("request table check failed");

`define CRT_ASSERT_NXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("request table check failed");

`else

`define CRT_ASSERT_IMP(lbl, ck, rn, ante, cons)

`define CRT_ASSERT_NXT(lbl, ck, rn, ante, cons)

`endif

`endif

[rtl/crt_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package crt_pkg;

    // Default table depth
    localparam int MAX_REQUESTS_DEF = 64;

    // Operation codes
    localparam logic OP_ADD   = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    // Coalescing policies
    localparam logic [2:0] POL_PLAIN          = 3'd0;
    localparam logic [2:0] POL_SYNC           = 3'd1;
    localparam logic [2:0] POL_IGN_REQ_ACTOR  = 3'd2;
    localparam logic [2:0] POL_IGN_REQ        = 3'd3;
    localparam logic [2:0] POL_IGN_ACTOR      = 3'd4;
    localparam logic [2:0] POL_OVR_REQ_ACTOR  = 3'd5;
    localparam logic [2:0] POL_OVR_REQ        = 3'd6;
    localparam logic [2:0] POL_OVR_ACTOR      = 3'd7;

    // Result status codes
    localparam logic [2:0] ST_APPENDED    = 3'd0;
    localparam logic [2:0] ST_FULL        = 3'd1;
    localparam logic [2:0] ST_SYNC        = 3'd2;
    localparam logic [2:0] ST_IGNORED     = 3'd3;
    localparam logic [2:0] ST_OVERWRITTEN = 3'd4;
    localparam logic [2:0] ST_CLEARED     = 3'd5;

    // Incoming transaction
    typedef struct packed {
        logic               operation;
        logic [15:0]        request_code;
        logic [15:0]        actor_id;
        logic [2:0]         policy;
        logic               sync_active;
        logic [31:0]        text_ref_one;
        logic [31:0]        text_ref_two;
        logic signed [31:0] arg_one;
        logic signed [31:0] arg_two;
        logic signed [31:0] arg_three;
        logic signed [31:0] arg_four;
    } crt_cmd_t;

    // Outgoing transaction
    typedef struct packed {
        logic [2:0] status;
        logic [6:0] entry_count;
        logic [6:0] replaced_count;
    } crt_rsp_t;

    // Query broadcast to every cell during a scan
    typedef struct packed {
        logic [15:0] req;
        logic [15:0] actor;
        logic [2:0]  pol;
        logic        scan;
        logic        use_req;
        logic        use_actor;
        logic        overwrite;
        logic [63:0] text;
        logic [63:0] args_low;
        logic [63:0] args_high;
    } crt_query_t;

    // Token handed from cell to cell
    typedef struct packed {
        logic active;
        logic found;
    } crt_tok_t;

    // Saturate a count to the 7-bit result fields
    function automatic logic [6:0] sat7(input logic [31:0] v);
        logic [6:0] r;
        r = (v > 32'd127) ? 7'd127 : v[6:0];
        return r;
    endfunction

endpackage

`default_nettype wire

[rtl/crt_cell.sv]
`timescale 1ns / 1ps
`default_nettype none

module crt_cell #(
    parameter int MAX_REQUESTS = crt_pkg::MAX_REQUESTS_DEF,
    parameter int CELL_IDX     = 0,
    localparam int CNT_W       = $clog2(MAX_REQUESTS + 1)
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic [CNT_W-1:0]    fill,
    input  wire crt_pkg::crt_query_t query,
    input  wire crt_pkg::crt_tok_t   tok_in,
    input  wire logic [CNT_W-1:0]    cnt_in,
    output crt_pkg::crt_tok_t        tok_out,
    output logic [CNT_W-1:0]         cnt_out
);
    import crt_pkg::*;

    localparam logic [CNT_W-1:0] IDX = CNT_W'(CELL_IDX);

    // Stored entry
    logic [15:0] key_req_reg;
    logic [15:0] key_actor_reg;
    logic [2:0]  key_pol_reg;
    logic [63:0] text_reg;
    logic [63:0] args_low_reg;
    logic [63:0] args_high_reg;

    crt_tok_t         tok_reg;
    crt_tok_t         tok_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;

    logic below;
    logic hit;
    logic match;
    logic wr_ovr;
    logic wr_app;
    logic wr;

    // Compare this entry against the query as the token passes
    always_comb
    begin
        below  = fill > IDX;
        hit    = (!query.use_req   || key_req_reg   == query.req) &&
                 (!query.use_actor || key_actor_reg == query.actor);
        match  = tok_in.active && below && query.scan && hit;
        wr_ovr = match && query.overwrite;
        // first free slot takes the new entry when nothing matched upstream
        wr_app = tok_in.active && (fill == IDX) && !tok_in.found;
        wr     = wr_ovr || wr_app;

        tok_next.active = tok_in.active;
        tok_next.found  = tok_in.found || match;
        cnt_next        = cnt_in + CNT_W'(wr_ovr);
    end

    // Token register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            key_req_reg   <= query.req;
            key_actor_reg <= query.actor;
            key_pol_reg   <= query.pol;
            text_reg      <= query.text;
            args_low_reg  <= query.args_low;
            args_high_reg <= query.args_high;
        end
    end

    assign tok_out = tok_reg;
    assign cnt_out = cnt_reg;

endmodule

`default_nettype wire

[rtl/coalescing_request_table.sv]
`timescale 1ns / 1ps
`default_nettype none
// Channel    Ports                  Handshake
// ---------  ---------------------  ------------------------------------
// command    start, busy, cmd       taken at an edge with start high, busy low
// result     done, rsp              valid for one cycle while done is high
//
// Clear, full-table and sync-held adds finish at once: done rises in the cycle after
// acceptance and busy stays low. Every other add sends a token down the row
// of MAX_REQUESTS cells, one cell per cycle, through the launch register, each
// cell's token register and then the done register; busy is high meanwhile.
// Reset empties the table. The receiver cannot stall results.
`include "coalescing_request_table_assert.svh"

module coalescing_request_table #(
    parameter int MAX_REQUESTS = crt_pkg::MAX_REQUESTS_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire crt_pkg::crt_cmd_t cmd,
    output logic               done,
    output crt_pkg::crt_rsp_t  rsp
);
    import crt_pkg::*;

    localparam int CNT_W = $clog2(MAX_REQUESTS + 1);
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_REQUESTS);

    logic [CNT_W-1:0] fill_reg;
    logic [CNT_W-1:0] fill_next;
    logic             busy_reg;
    logic             busy_next;
    logic             launch_reg;
    logic             launch_next;
    logic             done_reg;
    logic             done_next;
    crt_rsp_t         rsp_reg;
    crt_rsp_t         rsp_next;
    crt_query_t       query_reg;
    crt_query_t       query_next;

    crt_tok_t         tok_chain [0:MAX_REQUESTS];
    logic [CNT_W-1:0] cnt_chain [0:MAX_REQUESTS];
    logic [MAX_REQUESTS-1:0] tok_act;

    logic accept;
    logic scan_done;

    assign accept    = start && !busy_reg;
    assign scan_done = tok_chain[MAX_REQUESTS].active;

    // Token entering the first cell
    assign tok_chain[0].active = launch_reg;
    assign tok_chain[0].found  = 1'b0;
    assign cnt_chain[0]        = '0;

    // Row of cells
    for (genvar i = 0; i < MAX_REQUESTS; i++)
    begin : g_cell
        crt_cell #(
            .MAX_REQUESTS (MAX_REQUESTS),
            .CELL_IDX     (i)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .fill    (fill_reg),
            .query   (query_reg),
            .tok_in  (tok_chain[i]),
            .cnt_in  (cnt_chain[i]),
            .tok_out (tok_chain[i+1]),
            .cnt_out (cnt_chain[i+1])
        );
        assign tok_act[i] = tok_chain[i+1].active;
    end

    // Command decode and scan completion
    always_comb
    begin
        fill_next   = fill_reg;
        busy_next   = busy_reg;
        launch_next = 1'b0;
        done_next   = 1'b0;
        rsp_next    = rsp_reg;
        query_next  = query_reg;

        if (accept)
        begin
            done_next               = 1'b1;
            rsp_next.replaced_count = 7'd0;
            if (cmd.operation == OP_CLEAR)
            begin
                fill_next            = '0;
                rsp_next.status      = ST_CLEARED;
                rsp_next.entry_count = 7'd0;
            end
            else if (fill_reg >= MAX_CNT)
            begin
                rsp_next.status      = ST_FULL;
                rsp_next.entry_count = sat7(32'(fill_reg));
            end
            else if (cmd.policy == POL_SYNC && cmd.sync_active)
            begin
                rsp_next.status      = ST_SYNC;
                rsp_next.entry_count = sat7(32'(fill_reg));
            end
            else
            begin
                done_next            = 1'b0;
                busy_next            = 1'b1;
                launch_next          = 1'b1;
                query_next.req       = cmd.request_code;
                query_next.actor     = cmd.actor_id;
                query_next.pol       = cmd.policy;
                query_next.scan      = cmd.policy inside {[POL_IGN_REQ_ACTOR:POL_OVR_ACTOR]};
                query_next.use_req   = cmd.policy inside {POL_IGN_REQ_ACTOR, POL_IGN_REQ,
                                                          POL_OVR_REQ_ACTOR, POL_OVR_REQ};
                query_next.use_actor = cmd.policy inside {POL_IGN_REQ_ACTOR, POL_IGN_ACTOR,
                                                          POL_OVR_REQ_ACTOR, POL_OVR_ACTOR};
                query_next.overwrite = cmd.policy inside {[POL_OVR_REQ_ACTOR:POL_OVR_ACTOR]};
                query_next.text      = {cmd.text_ref_two, cmd.text_ref_one};
                query_next.args_low  = {cmd.arg_two, cmd.arg_one};
                query_next.args_high = {cmd.arg_four, cmd.arg_three};
            end
        end
        else if (scan_done)
        begin
            busy_next = 1'b0;
            done_next = 1'b1;
            if (tok_chain[MAX_REQUESTS].found)
            begin
                rsp_next.status = query_reg.overwrite ? ST_OVERWRITTEN : ST_IGNORED;
                rsp_next.replaced_count = query_reg.overwrite ?
                    sat7(32'(cnt_chain[MAX_REQUESTS])) : 7'd0;
            end
            else
            begin
                fill_next               = fill_reg + CNT_W'(1);
                rsp_next.status         = ST_APPENDED;
                rsp_next.replaced_count = 7'd0;
            end
            rsp_next.entry_count = sat7(32'(fill_next));
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg   <= '0;
            busy_reg   <= 1'b0;
            launch_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            fill_reg   <= fill_next;
            busy_reg   <= busy_next;
            launch_reg <= launch_next;
            done_reg   <= done_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        rsp_reg   <= rsp_next;
        query_reg <= query_next;
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign rsp  = rsp_reg;

    // At most one token in flight
    `CRT_ASSERT_IMP(a_one_token, clk, rst_n, 1'b1, $onehot0({tok_act, launch_reg}))
    // A token in the row means the block reports busy
    `CRT_ASSERT_IMP(a_busy_scan, clk, rst_n, launch_reg || tok_act != '0, busy_reg)
    // No result shown while a scan is under way
    `CRT_ASSERT_IMP(a_no_done_busy, clk, rst_n, busy_reg, !done_reg)
    // Replacement count only accompanies an overwrite, which replaced something
    `CRT_ASSERT_IMP(a_repl_cnt, clk, rst_n, done_reg,
                    (rsp_reg.status == ST_OVERWRITTEN) == (rsp_reg.replaced_count != 7'd0))
    // Fill level never exceeds the table depth
    `CRT_ASSERT_IMP(a_fill_max, clk, rst_n, 1'b1, fill_reg <= MAX_CNT)
    // A clear empties the table on the next cycle
    `CRT_ASSERT_NXT(a_clear, clk, rst_n, accept && cmd.operation == OP_CLEAR,
                    fill_reg == '0 && done_reg)

endmodule

`default_nettype wire
